// ----- src/vcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// vcsd_pkg
// Shared types and constants of the voxel column span decoder.
// ----------------------------------------------------------------------------
package vcsd_pkg;

  localparam int MAP_SIDE_DEF   = 512;
  localparam int MAP_DEPTH_DEF  = 64;
  localparam int BOTTOM_MAX_DEF = 63;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // one command per input byte that causes results or a buffer store
  typedef struct packed {
    logic        drain;       // emit buffered bottom colours
    logic        emit_color;  // emit one colour write (top or dropped)
    logic        store;       // buffer color at index count
    logic        emit_mask;   // emit the column mask after the rest
    logic [8:0]  x;
    logic [8:0]  y;
    logic [7:0]  air;         // air start of the header that drains
    logic [6:0]  count;       // bottom count to drain, or store index
    logic [5:0]  depth;
    logic        ovf;
    logic [31:0] color;
    logic [63:0] mask;
  } vcsd_cmd_t;

endpackage

// ----- src/vcsd_byte_if.sv -----
// ----------------------------------------------------------------------------
// vcsd_byte_if
// Byte stream channel: valid/ready with one map stream byte.
// ----------------------------------------------------------------------------
interface vcsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
  modport monitor (input valid, input data_byte, input ready);
endinterface

// ----- src/vcsd_result_if.sv -----
// ----------------------------------------------------------------------------
// vcsd_result_if
// Result channel: valid/ready with one colour write or column mask.
// ----------------------------------------------------------------------------
interface vcsd_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [8:0]  col_x;
  logic [8:0]  col_y;
  logic [5:0]  depth_z;
  logic [31:0] color_word;
  logic [63:0] solid_mask;
  logic        last;
  logic        overflow;

  modport source (output valid, output kind, output col_x, output col_y,
                  output depth_z, output color_word, output solid_mask,
                  output last, output overflow, input ready);
  modport sink (input valid, input kind, input col_x, input col_y,
                input depth_z, input color_word, input solid_mask,
                input last, input overflow, output ready);
  modport monitor (input valid, input kind, input col_x, input col_y,
                   input depth_z, input color_word, input solid_mask,
                   input last, input overflow, input ready);
endinterface

// ----- src/vcsd_front.sv -----
// ----------------------------------------------------------------------------
// vcsd_front
// Stream parser: tracks headers, colour words and column position, clears
// air runs from the mask and issues one command per productive byte.
// ----------------------------------------------------------------------------
module vcsd_front
  import vcsd_pkg::*;
#(
  parameter int MAP_SIDE   = MAP_SIDE_DEF,
  parameter int MAP_DEPTH  = MAP_DEPTH_DEF,
  parameter int BOTTOM_MAX = BOTTOM_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  vcsd_byte_if.sink     byte_ch,
  input  logic          q_full,
  output logic          q_push,
  output vcsd_cmd_t     q_data
);

  localparam int XW = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
  localparam logic [XW-1:0] X_LAST = XW'(MAP_SIDE - 1);
  localparam logic [63:0] FULL_MASK =
    (MAP_DEPTH >= 64) ? '1 : ((64'd1 << MAP_DEPTH) - 64'd1);
  localparam logic [7:0] DEPTH8 = 8'(MAP_DEPTH);
  localparam logic [6:0] DEPTH7 = 7'(MAP_DEPTH);
  localparam logic [6:0] BMAX7  = 7'(BOTTOM_MAX);

  logic [XW-1:0] column_x, column_x_next;
  logic [XW-1:0] column_y, column_y_next;
  logic [1:0]    byte_phase, byte_phase_next;
  logic          in_header, in_header_next;
  logic          first_span, first_span_next;
  logic [23:0]   header_bytes, header_bytes_next;
  logic [7:0]    colors_left_top, colors_left_top_next;
  logic [7:0]    colors_left_total, colors_left_total_next;
  logic [7:0]    next_top_depth, next_top_depth_next;
  logic [23:0]   color_shift, color_shift_next;
  logic [63:0]   column_mask, column_mask_next;
  logic [6:0]    bottom_count, bottom_count_next;

  logic        fire;
  logic [7:0]  b, cnt, s, e;
  logic [6:0]  fill, stop;
  logic [63:0] clr, mask_new;
  logic [8:0]  top9;
  logic [7:0]  top8, total, top_f, total_dec;
  logic [31:0] c;
  logic        end_col;

  assign byte_ch.ready = !q_full;
  assign fire = byte_ch.valid && byte_ch.ready;
  assign b    = byte_ch.data_byte;
  assign cnt  = header_bytes[7:0];
  assign s    = header_bytes[15:8];
  assign e    = header_bytes[23:16];
  assign c    = {b, color_shift};

  always_comb begin
    fill = 7'd0;
    if (!first_span) begin
      fill = (b < DEPTH8) ? b[6:0] : DEPTH7;
    end
    stop = (s < DEPTH8) ? s[6:0] : DEPTH7;
    for (int z = 0; z < 64; z++) begin
      clr[z] = (7'(z) >= fill) && (7'(z) < stop);
    end
    mask_new = column_mask & ~clr;
    top9 = (e >= s) ? ({1'b0, e} - {1'b0, s} + 9'd1) : 9'd0;
    top8 = top9[8] ? 8'd255 : top9[7:0];
    if (cnt == 8'd0) begin
      total = top8;
      top_f = top8;
    end else begin
      total = cnt - 8'd1;
      top_f = (top8 > total) ? total : top8;
    end
    total_dec = (colors_left_total != 8'd0) ? colors_left_total - 8'd1 : 8'd0;
  end

  always_comb begin
    column_x_next          = column_x;
    column_y_next          = column_y;
    byte_phase_next        = byte_phase;
    in_header_next         = in_header;
    first_span_next        = first_span;
    header_bytes_next      = header_bytes;
    colors_left_top_next   = colors_left_top;
    colors_left_total_next = colors_left_total;
    next_top_depth_next    = next_top_depth;
    color_shift_next       = color_shift;
    column_mask_next       = column_mask;
    bottom_count_next      = bottom_count;
    end_col                = 1'b0;
    q_push                 = 1'b0;
    q_data                 = '0;
    q_data.x               = 9'(column_x);
    q_data.y               = 9'(column_y);
    q_data.air             = b;
    q_data.count           = bottom_count;
    q_data.color           = c;

    if (fire) begin
      if (byte_phase != 2'd3) begin
        byte_phase_next = byte_phase + 2'd1;
        if (in_header) begin
          case (byte_phase)
            2'd0:    header_bytes_next = {16'd0, b};
            2'd1:    header_bytes_next[15:8] = b;
            default: header_bytes_next[23:16] = b;
          endcase
        end else begin
          case (byte_phase)
            2'd0:    color_shift_next = {16'd0, b};
            2'd1:    color_shift_next[15:8] = b;
            default: color_shift_next[23:16] = b;
          endcase
        end
      end else begin
        byte_phase_next = 2'd0;
        if (in_header) begin
          q_data.drain         = !first_span && (bottom_count != 7'd0);
          bottom_count_next    = 7'd0;
          first_span_next      = 1'b0;
          column_mask_next     = mask_new;
          colors_left_top_next = top_f;
          colors_left_total_next = total;
          next_top_depth_next  = s;
          q_data.mask          = mask_new;
          if (total == 8'd0) begin
            end_col = (cnt == 8'd0);
          end else begin
            in_header_next = 1'b0;
          end
        end else begin
          if (colors_left_top != 8'd0) begin
            q_data.emit_color    = 1'b1;
            q_data.ovf           = (next_top_depth >= DEPTH8);
            q_data.depth         = (next_top_depth < DEPTH8) ? next_top_depth[5:0] : 6'd0;
            next_top_depth_next  = (next_top_depth != 8'd255) ? next_top_depth + 8'd1 : 8'd255;
            colors_left_top_next = colors_left_top - 8'd1;
          end else if (bottom_count < BMAX7) begin
            q_data.store      = 1'b1;
            bottom_count_next = bottom_count + 7'd1;
          end else begin
            q_data.emit_color = 1'b1;
            q_data.ovf        = 1'b1;
          end
          colors_left_total_next = total_dec;
          q_data.mask = column_mask;
          if (total_dec == 8'd0) begin
            if (cnt == 8'd0) begin
              end_col = 1'b1;
            end else begin
              in_header_next = 1'b1;
            end
          end
        end
        q_data.emit_mask = end_col;
        q_push = q_data.drain || q_data.emit_color || q_data.store || end_col;
        if (end_col) begin
          column_mask_next  = FULL_MASK;
          first_span_next   = 1'b1;
          bottom_count_next = 7'd0;
          in_header_next    = 1'b1;
          if (column_x == X_LAST) begin
            column_x_next = '0;
            column_y_next = (column_y == X_LAST) ? '0 : column_y + XW'(1);
          end else begin
            column_x_next = column_x + XW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_x          <= '0;
      column_y          <= '0;
      byte_phase        <= 2'd0;
      in_header         <= 1'b1;
      first_span        <= 1'b1;
      header_bytes      <= 24'd0;
      colors_left_top   <= 8'd0;
      colors_left_total <= 8'd0;
      next_top_depth    <= 8'd0;
      color_shift       <= 24'd0;
      column_mask       <= FULL_MASK;
      bottom_count      <= 7'd0;
    end else begin
      column_x          <= column_x_next;
      column_y          <= column_y_next;
      byte_phase        <= byte_phase_next;
      in_header         <= in_header_next;
      first_span        <= first_span_next;
      header_bytes      <= header_bytes_next;
      colors_left_top   <= colors_left_top_next;
      colors_left_total <= colors_left_total_next;
      next_top_depth    <= next_top_depth_next;
      color_shift       <= color_shift_next;
      column_mask       <= column_mask_next;
      bottom_count      <= bottom_count_next;
    end
  end

endmodule

// ----- src/vcsd_queue.sv -----
// ----------------------------------------------------------------------------
// vcsd_queue
// Small command FIFO between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module vcsd_queue
  import vcsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vcsd_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output vcsd_cmd_t pop_data,
  output logic      empty
);

  vcsd_cmd_t       entries [Q_DEPTH];
  logic [Q_AW-1:0] wptr, rptr;
  logic [Q_AW:0]   fill;

  assign full     = (fill == (Q_AW + 1)'(Q_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (Q_AW + 1)'(1);
        2'b01:   fill <= fill - (Q_AW + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/vcsd_back.sv -----
// ----------------------------------------------------------------------------
// vcsd_back
// Result sequencer: holds the bottom colour buffer, replays buffered
// colours at their depths, and drives the registered result channel.
// ----------------------------------------------------------------------------
module vcsd_back
  import vcsd_pkg::*;
#(
  parameter int MAP_DEPTH  = MAP_DEPTH_DEF,
  parameter int BOTTOM_MAX = BOTTOM_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  vcsd_cmd_t       q_data,
  output logic            q_pop,
  vcsd_result_if.source   result_ch
);

  localparam int IW = (BOTTOM_MAX > 1) ? $clog2(BOTTOM_MAX) : 1;
  localparam logic [9:0] DEPTH10 = 10'(MAP_DEPTH);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_READ  = 5'b00010,
    B_BOT   = 5'b00100,
    B_COLOR = 5'b01000,
    B_MASK  = 5'b10000
  } vcsd_bstate_t;

  typedef struct packed {
    logic        kind;
    logic [8:0]  col_x;
    logic [8:0]  col_y;
    logic [5:0]  depth_z;
    logic [31:0] color_word;
    logic [63:0] solid_mask;
    logic        last;
    logic        overflow;
  } vcsd_res_t;

  logic [31:0]  buffer [BOTTOM_MAX];
  logic [31:0]  rd_data;
  vcsd_bstate_t state, state_next;
  vcsd_cmd_t    cur;
  logic [6:0]   idx, idx_next;
  logic         res_valid, slot_free, load_out, last_bot;
  vcsd_res_t    res, res_next;
  logic [9:0]   d;

  assign slot_free = !res_valid || result_ch.ready;
  assign last_bot  = (idx + 7'd1 == cur.count);
  assign d = {2'b00, cur.air} - {3'b000, cur.count} + {3'b000, idx};

  always_comb begin
    state_next = state;
    idx_next   = idx;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    res_next   = '0;
    res_next.col_x = cur.x;
    res_next.col_y = cur.y;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          idx_next = 7'd0;
          if (q_data.drain) begin
            state_next = B_READ;
          end else if (q_data.emit_color) begin
            state_next = B_COLOR;
          end else if (q_data.emit_mask) begin
            state_next = B_MASK;
          end
        end
      end
      B_READ: state_next = B_BOT;
      B_BOT: begin
        if (slot_free) begin
          load_out = 1'b1;
          res_next.color_word = rd_data;
          res_next.overflow   = d[9] || (d >= DEPTH10);
          res_next.depth_z    = res_next.overflow ? 6'd0 : d[5:0];
          res_next.last       = last_bot && !cur.emit_mask;
          if (last_bot) begin
            state_next = cur.emit_mask ? B_MASK : B_IDLE;
          end else begin
            idx_next   = idx + 7'd1;
            state_next = B_READ;
          end
        end
      end
      B_COLOR: begin
        if (slot_free) begin
          load_out = 1'b1;
          res_next.color_word = cur.color;
          res_next.overflow   = cur.ovf;
          res_next.depth_z    = cur.depth;
          res_next.last       = !cur.emit_mask;
          state_next = cur.emit_mask ? B_MASK : B_IDLE;
        end
      end
      B_MASK: begin
        if (slot_free) begin
          load_out = 1'b1;
          res_next.kind       = 1'b1;
          res_next.solid_mask = cur.mask;
          res_next.last       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.store) begin
      buffer[q_data.count[IW-1:0]] <= q_data.color;
    end
    rd_data <= buffer[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (load_out) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= 7'd0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result_ch.valid      = res_valid;
  assign result_ch.kind       = res.kind;
  assign result_ch.col_x      = res.col_x;
  assign result_ch.col_y      = res.col_y;
  assign result_ch.depth_z    = res.depth_z;
  assign result_ch.color_word = res.color_word;
  assign result_ch.solid_mask = res.solid_mask;
  assign result_ch.last       = res.last;
  assign result_ch.overflow   = res.overflow;

endmodule

// ----- src/voxel_column_span_decoder.sv -----
// ----------------------------------------------------------------------------
// voxel_column_span_decoder
// Decodes a span-encoded voxel map byte stream into per-voxel colour writes
// and one solid mask per column.
//
// byte_ch takes one stream byte per transaction; result_ch gives one colour
// write (kind 0) or column mask (kind 1) per transaction, with last set on
// the final result caused by a byte. The parser takes one byte per cycle
// while its 4-entry command queue has room. A result passes through the
// command queue, the sequencer's command register and the output register.
// The sequencer pops a queued colour or mask command and then loads the
// output register, and loads a mask behind a colour or a bottom run after
// that; each buffered bottom colour passes through B_READ and B_BOT, as the
// read of the bottom buffer is registered. Every command is paid for by at
// least four bytes, but a long bottom drain can still fill the queue.
// Reset (rst, synchronous) returns to the first header of column (0,0);
// the bottom buffer needs no clearing pass. A stall on result_ch holds the
// output register; the parser keeps taking bytes until the queue fills,
// then drops byte_ch.ready.
// ----------------------------------------------------------------------------
module voxel_column_span_decoder
  import vcsd_pkg::*;
#(
  parameter int MAP_SIDE   = MAP_SIDE_DEF,
  parameter int MAP_DEPTH  = MAP_DEPTH_DEF,
  parameter int BOTTOM_MAX = BOTTOM_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  vcsd_byte_if.sink     byte_ch,
  vcsd_result_if.source result_ch
);

  logic      q_push, q_pop, q_full, q_empty;
  vcsd_cmd_t q_in, q_out;

  vcsd_front #(
    .MAP_SIDE   (MAP_SIDE),
    .MAP_DEPTH  (MAP_DEPTH),
    .BOTTOM_MAX (BOTTOM_MAX)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  vcsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  vcsd_back #(
    .MAP_DEPTH  (MAP_DEPTH),
    .BOTTOM_MAX (BOTTOM_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .result_ch (result_ch)
  );

endmodule

// ----- src/vcsd_checker.sv -----
// ----------------------------------------------------------------------------
// vcsd_checker
// Port-level checks on the decoder's result channel, bound to the top.
// ----------------------------------------------------------------------------
module vcsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        kind,
  input logic [8:0]  col_x,
  input logic [8:0]  col_y,
  input logic [5:0]  depth_z,
  input logic [31:0] color_word,
  input logic [63:0] solid_mask,
  input logic        last,
  input logic        overflow
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(kind) &&
      $stable(color_word) && $stable(solid_mask) && $stable(last))
    else $error("stalled result changed");

  a_mask_form: assert property (@(posedge clk) disable iff (rst)
    valid && kind |-> last && depth_z == 6'd0 &&
      color_word == 32'd0 && !overflow)
    else $error("malformed mask result");

  a_color_form: assert property (@(posedge clk) disable iff (rst)
    valid && !kind |-> solid_mask == 64'd0 &&
      (!overflow || depth_z == 6'd0))
    else $error("malformed colour result");

  a_mask_after_last: assert property (@(posedge clk) disable iff (rst)
    valid && ready && kind |=> !valid || !kind ||
      col_x != $past(col_x) || col_y != $past(col_y))
    else $error("mask repeated for one column");

endmodule

bind voxel_column_span_decoder vcsd_checker u_vcsd_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (result_ch.valid),
  .ready      (result_ch.ready),
  .kind       (result_ch.kind),
  .col_x      (result_ch.col_x),
  .col_y      (result_ch.col_y),
  .depth_z    (result_ch.depth_z),
  .color_word (result_ch.color_word),
  .solid_mask (result_ch.solid_mask),
  .last       (result_ch.last),
  .overflow   (result_ch.overflow)
);
